/* hdl/rawp_pkg.sv */
package rawp_pkg;

  localparam int INDEX_BITS = 32;
  localparam int SIZE_BITS  = 16;
  // Width that holds a sum of two or three window sizes without overflow.
  localparam int GROW_BITS  = SIZE_BITS + 2;

  localparam int IN_FIELD_BITS  = 4 * INDEX_BITS + 2 * SIZE_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = INDEX_BITS + 2 * SIZE_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int ACTION_BITS    = 2;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEV_IO    = 1'd1;

  localparam logic [SIZE_BITS-1:0] WIN_LIMIT_RESET = SIZE_BITS'(32);
  localparam logic [SIZE_BITS-1:0] DEV_IO_RESET    = '0;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [GROW_BITS-1:0]  grow_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_NONE   = 2'd0,
    ACT_WINDOW = 2'd1,
    ACT_PLAIN  = 2'd2
  } action_t;

  // Last member sits in the lowest bits, so page_index lands at bit 0.
  typedef struct packed {
    logic  kind;
    idx_t  file_pages;
    size_t history_count;
    idx_t  next_miss;
    idx_t  prev_page;
    size_t req_len;
    idx_t  page_index;
  } item_t;

  typedef struct packed {
    size_t mark_offset;
    size_t read_count;
    idx_t  read_start;
  } result_t;

  typedef struct packed {
    size_t dev_io;
    size_t win_limit;
  } cfg_t;

  // Decision before end-of-file clipping.
  typedef struct packed {
    action_t action;
    idx_t    file_pages;
    result_t res;
  } mid_t;

  // Window growth step: quadruple small windows, double medium ones, else the limit.
  function automatic size_t next_size(input grow_t cur, input size_t lim);
    grow_t lim_w;
    lim_w = GROW_BITS'(lim);
    if (cur < (lim_w >> 4)) begin
      next_size = SIZE_BITS'(cur << 2);
    end else if (cur <= (lim_w >> 1)) begin
      next_size = SIZE_BITS'(cur << 1);
    end else begin
      next_size = lim;
    end
  endfunction

  // Initial window: request rounded up to a power of two, then scaled.
  function automatic size_t init_size(input size_t req, input size_t lim);
    logic [SIZE_BITS:0] x;
    logic [SIZE_BITS:0] p;
    logic [SIZE_BITS:0] lim_w;
    x = {1'b0, req} - (SIZE_BITS + 1)'(1);
    for (int s = 1; s < SIZE_BITS; s = s * 2) begin
      x = x | (x >> s);
    end
    p = x + (SIZE_BITS + 1)'(1);
    if (req <= SIZE_BITS'(1)) begin
      p = (SIZE_BITS + 1)'(1);
    end
    lim_w = {1'b0, lim};
    if (p <= (lim_w >> 5)) begin
      init_size = SIZE_BITS'(p << 2);
    end else if (p <= (lim_w >> 2)) begin
      init_size = SIZE_BITS'(p << 1);
    end else begin
      init_size = lim;
    end
  endfunction

endpackage

/* hdl/rawp_decide.sv */
module rawp_decide (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  rawp_pkg::item_t item,
  input  rawp_pkg::cfg_t  cfg,
  output rawp_pkg::mid_t  mid
);

  typedef enum logic [2:0] {
    P_INIT,
    P_RAMP,
    P_MARK,
    P_CTX,
    P_PLAIN,
    P_NONE
  } path_t;

  rawp_pkg::idx_t  win_start;
  rawp_pkg::size_t win_size;
  rawp_pkg::size_t win_async;
  rawp_pkg::idx_t  win_start_next;
  rawp_pkg::size_t win_size_next;
  rawp_pkg::size_t win_async_next;

  rawp_pkg::size_t lim;
  rawp_pkg::idx_t  ramp_end;
  rawp_pkg::idx_t  ramp_mark;
  rawp_pkg::idx_t  gap;
  rawp_pkg::idx_t  step;
  rawp_pkg::grow_t hist_w;
  rawp_pkg::grow_t ctx_sz;
  rawp_pkg::grow_t merge_sum;
  rawp_pkg::size_t merge_add;
  rawp_pkg::size_t init_sz;
  rawp_pkg::size_t bsz;
  rawp_pkg::size_t ba;
  rawp_pkg::idx_t  bs;
  path_t           path;

  always_comb begin
    // Effective limit: a large request may widen it up to the device I/O size.
    if (item.req_len > cfg.win_limit && cfg.dev_io > cfg.win_limit) begin
      lim = (item.req_len < cfg.dev_io) ? item.req_len : cfg.dev_io;
    end else begin
      lim = cfg.win_limit;
    end

    ramp_end  = win_start + rawp_pkg::INDEX_BITS'(win_size);
    ramp_mark = ramp_end - rawp_pkg::INDEX_BITS'(win_async);
    gap       = item.next_miss - item.page_index;
    step      = item.page_index - item.prev_page;

    if (item.page_index == '0) begin
      path = P_INIT;
    end else if (item.page_index == ramp_mark || item.page_index == ramp_end) begin
      path = P_RAMP;
    end else if (item.kind) begin
      if (item.next_miss == '0 || gap > rawp_pkg::INDEX_BITS'(lim)) begin
        path = P_NONE;
      end else begin
        path = P_MARK;
      end
    end else if (item.req_len > lim) begin
      path = P_INIT;
    end else if (step <= rawp_pkg::INDEX_BITS'(1)) begin
      path = P_INIT;
    end else if (item.history_count > item.req_len) begin
      path = P_CTX;
    end else begin
      path = P_PLAIN;
    end

    hist_w = rawp_pkg::GROW_BITS'(item.history_count);
    if (rawp_pkg::INDEX_BITS'(item.history_count) >= item.page_index) begin
      hist_w = hist_w << 1;
    end
    ctx_sz  = hist_w + rawp_pkg::GROW_BITS'(item.req_len);
    init_sz = rawp_pkg::init_size(item.req_len, lim);

    bs  = item.page_index;
    bsz = init_sz;
    ba  = (init_sz > item.req_len) ? init_sz - item.req_len : init_sz;
    case (path)
      P_INIT: begin
      end
      P_RAMP: begin
        bs  = ramp_end;
        bsz = rawp_pkg::next_size(rawp_pkg::GROW_BITS'(win_size), lim);
        ba  = bsz;
      end
      P_MARK: begin
        bs  = item.next_miss;
        bsz = rawp_pkg::next_size(rawp_pkg::GROW_BITS'(gap[rawp_pkg::SIZE_BITS-1:0]) +
                                  rawp_pkg::GROW_BITS'(item.req_len), lim);
        ba  = bsz;
      end
      P_CTX: begin
        bsz = (ctx_sz < rawp_pkg::GROW_BITS'(lim)) ? ctx_sz[rawp_pkg::SIZE_BITS-1:0] : lim;
        ba  = rawp_pkg::SIZE_BITS'(1);
      end
      default: begin
      end
    endcase

    // A window whose marker sits on its own first page takes in the next window.
    merge_add = rawp_pkg::next_size(rawp_pkg::GROW_BITS'(bsz), lim);
    merge_sum = rawp_pkg::GROW_BITS'(bsz) + rawp_pkg::GROW_BITS'(merge_add);
    if (item.page_index == bs && bsz == ba) begin
      if (merge_sum <= rawp_pkg::GROW_BITS'(lim)) begin
        ba  = merge_add;
        bsz = merge_sum[rawp_pkg::SIZE_BITS-1:0];
      end else begin
        bsz = lim;
        ba  = lim >> 1;
      end
    end

    win_start_next = win_start;
    win_size_next  = win_size;
    win_async_next = win_async;
    mid.file_pages = item.file_pages;
    case (path)
      P_NONE: begin
        mid.action = rawp_pkg::ACT_NONE;
        mid.res    = '0;
      end
      P_PLAIN: begin
        mid.action = rawp_pkg::ACT_PLAIN;
        mid.res.read_start  = item.page_index;
        mid.res.read_count  = item.req_len;
        mid.res.mark_offset = '0;
      end
      default: begin
        mid.action = rawp_pkg::ACT_WINDOW;
        mid.res.read_start  = bs;
        mid.res.read_count  = bsz;
        mid.res.mark_offset = ba;
        win_start_next = bs;
        win_size_next  = bsz;
        win_async_next = ba;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_start <= '0;
      win_size  <= '0;
      win_async <= '0;
    end else if (fire) begin
      win_start <= win_start_next;
      win_size  <= win_size_next;
      win_async <= win_async_next;
    end
  end

endmodule

/* hdl/rawp_clip.sv */
module rawp_clip (
  input  rawp_pkg::mid_t    mid,
  output rawp_pkg::action_t action,
  output rawp_pkg::result_t res
);

  rawp_pkg::idx_t last;
  rawp_pkg::idx_t room;

  always_comb begin
    last = mid.file_pages - rawp_pkg::INDEX_BITS'(1);
    room = last - mid.res.read_start;
    action = mid.action;
    res    = mid.res;
    // Nothing is fetched for an empty file, an empty range or a start past the end.
    if (mid.action == rawp_pkg::ACT_NONE || mid.file_pages == '0 ||
        mid.res.read_count == '0 || mid.res.read_start > last) begin
      action = rawp_pkg::ACT_NONE;
      res    = '0;
    end else if (rawp_pkg::INDEX_BITS'(mid.res.read_count) > room) begin
      res.read_count = rawp_pkg::SIZE_BITS'(room + rawp_pkg::INDEX_BITS'(1));
    end
  end

endmodule

/* hdl/readahead_window_policy.sv */
// A result passes through the input register, decision register and output register,
// held longer only while the output is stalled. Throughput: one read request per cycle
// while the output is not stalled; the window state updates as a request leaves the
// input register, so the next request sees it with no bubble.
// Reset (synchronous, active high) clears the window to zero, empties all stages and
// sets the window limit to 32 pages and the device I/O size to 0.
module readahead_window_policy (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // page_index, req_len, prev_page, next_miss, history_count, file_pages
  input  logic [rawp_pkg::IN_DATA_BITS-1:0]       s_tdata,
  // kind
  input  logic                                    s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // read_start, read_count, mark_offset
  output logic [rawp_pkg::OUT_DATA_BITS-1:0]      m_tdata,
  // action
  output logic [rawp_pkg::ACTION_BITS-1:0]        m_tuser,
  input  logic                                    cfg_we,
  input  logic [rawp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [rawp_pkg::SIZE_BITS-1:0]          cfg_wdata
);

  // Configuration registers. Writes are expected only while the block is idle.
  rawp_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_limit <= rawp_pkg::WIN_LIMIT_RESET;
      cfg.dev_io    <= rawp_pkg::DEV_IO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rawp_pkg::REG_WIN_LIMIT: cfg.win_limit <= cfg_wdata;
        rawp_pkg::REG_DEV_IO:    cfg.dev_io    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Three stages: input register, decision register, output register. Each stage
  // moves on when the one after it is empty or moving on in the same cycle, so a
  // stall at the output only blocks the input once every stage holds a request.
  logic              s1_valid;
  rawp_pkg::item_t   s1_item;
  logic              s2_valid;
  rawp_pkg::mid_t    s2_mid;
  rawp_pkg::action_t out_action;
  rawp_pkg::result_t out_res;

  logic out_free;
  logic s2_free;
  logic s1_free;
  logic s1_adv;

  rawp_pkg::mid_t    dec_mid;
  rawp_pkg::action_t clip_action;
  rawp_pkg::result_t clip_res;

  assign out_free = !m_tvalid || m_tready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_adv   = s1_valid && s2_free;
  assign s_tready = s1_free;

  // The decision stage owns the window state; it commits when a request advances.
  rawp_decide u_decide (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_adv),
    .item (s1_item),
    .cfg  (cfg),
    .mid  (dec_mid)
  );

  // End-of-file clipping sits between the decision and output registers.
  rawp_clip u_clip (
    .mid    (s2_mid),
    .action (clip_action),
    .res    (clip_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= s_tvalid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        m_tvalid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && s_tvalid) begin
      s1_item <= {s_tuser, s_tdata[rawp_pkg::IN_FIELD_BITS-1:0]};
    end
    if (s1_adv) begin
      s2_mid <= dec_mid;
    end
    if (out_free && s2_valid) begin
      out_action <= clip_action;
      out_res    <= clip_res;
    end
  end

  assign m_tdata = rawp_pkg::OUT_DATA_BITS'(out_res);
  assign m_tuser = out_action;

  // An empty fetch carries no range and no marker.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_action == rawp_pkg::ACT_NONE) |-> (out_res == '0))
    else $error("empty fetch with nonzero fields");

  // Any fetch that is issued covers at least one page.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_action != rawp_pkg::ACT_NONE) |-> (out_res.read_count != '0))
    else $error("fetch issued with zero pages");

  // A plain read never places a marker.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_action == rawp_pkg::ACT_PLAIN) |-> (out_res.mark_offset == '0))
    else $error("plain read carries a marker");

  // The input side only stalls when every stage is full and the output is held.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s2_valid && m_tvalid && !m_tready))
    else $error("input stalled without an output stall");

endmodule

/* tb/readahead_window_policy_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the readahead window policy. Read requests go out on
// the slave stream from a queue, and each accepted transfer is run through a
// local model of the window so that the expected fetch is known in advance.
// Fetch results are checked field by field, in order, on the master stream.
module readahead_window_policy_tb;

  typedef logic [63:0] wide_t;

  localparam wide_t IDX_MASK = 64'hFFFF_FFFF;
  localparam wide_t SZ_MASK  = 64'hFFFF;

  // Request kinds as they travel on s_tuser.
  localparam logic KIND_SYNC   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  localparam int unsigned    QUIET_LIMIT = 2000;
  localparam int unsigned    PHASE_ITEMS = 150;
  localparam rawp_pkg::idx_t BIG_FILE    = 32'hF000_0000;

  // Limit settings for the random phases; the last phase draws its own.
  localparam int unsigned PHASE_MAX [0:7] = '{32, 1, 65535, 16, 128, 4, 65535, 512};
  localparam int unsigned PHASE_IO  [0:7] = '{0, 0, 65535, 256, 64, 65535, 0, 1024};

  typedef struct packed {
    logic            kind;
    rawp_pkg::idx_t  page_index;
    rawp_pkg::size_t req_len;
    rawp_pkg::idx_t  prev_page;
    rawp_pkg::idx_t  next_miss;
    rawp_pkg::size_t history_count;
    rawp_pkg::idx_t  file_pages;
  } request_t;

  typedef struct packed {
    rawp_pkg::action_t action;
    rawp_pkg::idx_t    read_start;
    rawp_pkg::size_t   read_count;
    rawp_pkg::size_t   mark_offset;
  } fetch_t;

  // Readahead window: first page, size, and distance of the marker from the end.
  typedef struct packed {
    wide_t start;
    wide_t span;
    wide_t lead;
  } window_t;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                s_tvalid  = 1'b0;
  logic                                s_tready;
  logic [rawp_pkg::IN_DATA_BITS-1:0]   s_tdata   = '0;
  logic                                s_tuser   = 1'b0;
  logic                                m_tvalid;
  logic                                m_tready  = 1'b0;
  logic [rawp_pkg::OUT_DATA_BITS-1:0]  m_tdata;
  logic [rawp_pkg::ACTION_BITS-1:0]    m_tuser;
  logic                                cfg_we    = 1'b0;
  logic [rawp_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [rawp_pkg::SIZE_BITS-1:0]      cfg_wdata = '0;

  // Limits as the block holds them; 32 and 0 after reset.
  wide_t cfg_max = 64'd32;
  wide_t cfg_io  = 64'd0;

  // The window as seen by accepted transfers, and a second copy that runs ahead
  // while requests are generated so that sequential reads can aim at the marker.
  window_t file_window   = '0;
  window_t plan_window   = '0;

  request_t read_requests [$];
  fetch_t   pending_fetches [$];
  request_t sent_req;
  fetch_t   want;

  logic        src_idle   = 1'b1;
  logic        sink_idle  = 1'b1;
  int unsigned send_gap   = 0;
  int unsigned hold_off   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  readahead_window_policy DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Growth step: small windows quadruple, medium ones double, else the limit.
  function automatic wide_t grow_step(input wide_t cur, input wide_t lim);
    if (cur < lim / 16) return 4 * cur;
    if (cur <= lim / 2) return 2 * cur;
    return lim;
  endfunction

  // First window size: request rounded up to a power of two, then scaled.
  function automatic wide_t first_window(input wide_t req, input wide_t lim);
    wide_t p;
    p = 1;
    while (p < req) p = p << 1;
    if (p <= lim / 32) return p * 4;
    if (p <= lim / 4) return p * 2;
    return lim;
  endfunction

  // Clips the fetch at end of file. An empty fetch reports no action at all.
  function automatic fetch_t clip_fetch(input rawp_pkg::action_t act, input wide_t first,
                                        input wide_t count, input wide_t mark,
                                        input wide_t pages);
    fetch_t res;
    wide_t  last_page;
    res = '0;
    res.action = rawp_pkg::ACT_NONE;
    if (pages == 0 || count == 0) return res;
    last_page = pages - 1;
    if (first > last_page) return res;
    if (count > last_page - first) count = last_page - first + 1;
    res.action      = act;
    res.read_start  = first[rawp_pkg::INDEX_BITS-1:0];
    res.read_count  = count[rawp_pkg::SIZE_BITS-1:0];
    res.mark_offset = mark[rawp_pkg::SIZE_BITS-1:0];
    return res;
  endfunction

  // Decides one read request against window w and returns the fetch it causes.
  function automatic fetch_t decide_fetch(inout window_t w, input request_t r,
                                          input wide_t max_p, input wide_t io_p);
    wide_t idx, req, prev, miss, hist, pages, lim, sz, extra, gap;
    logic  open_new;
    idx   = 64'(r.page_index);
    req   = 64'(r.req_len);
    prev  = 64'(r.prev_page);
    miss  = 64'(r.next_miss);
    hist  = 64'(r.history_count);
    pages = 64'(r.file_pages);
    open_new = 1'b0;

    // A large request may widen the limit up to the device I/O size.
    lim = max_p;
    if (req > lim && io_p > lim) lim = (req < io_p) ? req : io_p;

    if (idx == 0) begin
      open_new = 1'b1;
    end else if (idx == ((w.start + w.span - w.lead) & IDX_MASK) ||
                 idx == ((w.start + w.span) & IDX_MASK)) begin
      // Sequential hit on the marker or at the window end: ramp up.
      w.start = (w.start + w.span) & IDX_MASK;
      w.span  = grow_step(w.span, lim) & SZ_MASK;
      w.lead  = w.span;
    end else if (r.kind == KIND_MARKER) begin
      // Marker hit with no matching state: rebuild from the cache probe.
      gap = (miss - idx) & IDX_MASK;
      if (miss == 0 || gap > lim) return clip_fetch(rawp_pkg::ACT_NONE, 0, 0, 0, 0);
      w.start = miss;
      w.span  = grow_step(gap + req, lim) & SZ_MASK;
      w.lead  = w.span;
    end else if (req > lim || ((idx - prev) & IDX_MASK) <= 1) begin
      open_new = 1'b1;
    end else if (hist > req) begin
      // Cached history before the request suggests a sequential stream.
      sz = hist;
      if (sz >= idx) sz = sz * 2;
      sz = sz + req;
      w.start = idx;
      w.span  = ((sz < lim) ? sz : lim) & SZ_MASK;
      w.lead  = 1;
    end else begin
      // Random read: fetch only the request and leave the window alone.
      return clip_fetch(rawp_pkg::ACT_PLAIN, idx, req, 0, pages);
    end

    if (open_new) begin
      w.start = idx;
      w.span  = first_window(req, lim) & SZ_MASK;
      w.lead  = (w.span > req) ? w.span - req : w.span;
    end

    // A marker on the window's own first page would trigger at once, so the
    // next window is merged in right away.
    if (idx == w.start && w.span == w.lead) begin
      extra = grow_step(w.span, lim);
      if (w.span + extra <= lim) begin
        w.lead = extra & SZ_MASK;
        w.span = (w.span + extra) & SZ_MASK;
      end else begin
        w.span = lim & SZ_MASK;
        w.lead = (lim >> 1) & SZ_MASK;
      end
    end
    return clip_fetch(rawp_pkg::ACT_WINDOW, w.start, w.span, w.lead, pages);
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_req_len();
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(99);
    top  = 32'(cfg_max) * 2 + 1;
    if (top > 65535) top = 65535;
    if (roll < 50) return $urandom_range(1, 8);
    if (roll < 80) return $urandom_range(1, 64);
    if (roll < 92) return $urandom_range(1, top);
    if (roll < 97) return $urandom_range(1, 65535);
    return 65535;
  endfunction

  // Queues a request and advances the look-ahead copy of the window.
  function automatic void queue_request(input request_t r);
    read_requests.push_back(r);
    void'(decide_fetch(plan_window, r, cfg_max, cfg_io));
  endfunction

  function automatic void add_request(input logic kind, input rawp_pkg::idx_t page,
                                      input rawp_pkg::size_t req,
                                      input rawp_pkg::idx_t prev,
                                      input rawp_pkg::idx_t miss,
                                      input rawp_pkg::size_t hist,
                                      input rawp_pkg::idx_t pages);
    request_t r;
    r.kind          = kind;
    r.page_index    = page;
    r.req_len       = req;
    r.prev_page     = prev;
    r.next_miss     = miss;
    r.history_count = hist;
    r.file_pages    = pages;
    queue_request(r);
  endfunction

  // Half of the random requests follow the window so that it keeps ramping;
  // the rest are marker rebuilds, restarts, context reads and plain noise.
  function automatic request_t make_request();
    request_t    r;
    int unsigned pick;
    int unsigned hist;
    r.kind          = 1'($urandom_range(1));
    r.page_index    = $urandom;
    r.req_len       = rawp_pkg::size_t'(pick_req_len());
    r.prev_page     = $urandom;
    r.next_miss     = $urandom;
    r.history_count = ($urandom_range(3) == 0) ? rawp_pkg::size_t'($urandom_range(65535))
                                                : rawp_pkg::size_t'($urandom_range(64));
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.page_index = rawp_pkg::idx_t'(plan_window.start + plan_window.span - plan_window.lead);
      r.kind       = ($urandom_range(3) != 0) ? KIND_MARKER : KIND_SYNC;
      r.prev_page  = r.page_index - 1;
    end else if (pick < 50) begin
      r.page_index = rawp_pkg::idx_t'(plan_window.start + plan_window.span);
      r.prev_page  = r.page_index - 1;
    end else if (pick < 60) begin
      r.kind      = KIND_MARKER;
      r.next_miss = ($urandom_range(7) == 0) ? '0
                    : r.page_index + rawp_pkg::idx_t'($urandom_range(32'(cfg_max) + 8));
    end else if (pick < 68) begin
      r.prev_page = r.page_index - rawp_pkg::idx_t'($urandom_range(1));
    end else if (pick < 78) begin
      r.kind = KIND_SYNC;
      if ($urandom_range(3) == 0) r.page_index = rawp_pkg::idx_t'($urandom_range(1, 300));
      r.prev_page = r.page_index + rawp_pkg::idx_t'($urandom_range(2, 1000));
      hist = 32'(r.req_len) + $urandom_range(1, 300);
      r.history_count = rawp_pkg::size_t'((hist > 65535) ? 65535 : hist);
    end else if (pick < 85) begin
      r.page_index = '0;
    end

    pick = $urandom_range(9);
    if (pick < 6) begin
      r.file_pages = r.page_index + 32'd100000 +
                     rawp_pkg::idx_t'($urandom_range(32'd1 << 20));
    end else if (pick < 8) begin
      r.file_pages = r.page_index + rawp_pkg::idx_t'($urandom_range(40));
    end else if (pick == 8) begin
      r.file_pages = '0;
    end else begin
      r.file_pages = $urandom;
    end
    return r;
  endfunction

  // Returns once no request is queued or in flight and every fetch has come back.
  // The check runs on the falling edge, after all clocked updates have settled.
  task automatic wait_idle();
    while (read_requests.size() != 0 || s_tvalid || pending_fetches.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes the window limit register, then the device I/O register; only called while idle.
  task automatic set_limits(input int unsigned max_val, input int unsigned io_val);
    cfg_we    <= 1'b1;
    cfg_index <= rawp_pkg::REG_WIN_LIMIT;
    cfg_wdata <= rawp_pkg::size_t'(max_val);
    @(posedge clk);
    cfg_index <= rawp_pkg::REG_DEV_IO;
    cfg_wdata <= rawp_pkg::size_t'(io_val);
    @(posedge clk);
    cfg_we  <= 1'b0;
    cfg_max = 64'(max_val & 32'hFFFF);
    cfg_io  = 64'(io_val & 32'hFFFF);
  endtask

  // Request driver. A request is popped when the slot is free and any gap
  // chosen after the previous transfer has run out.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        pending_fetches.push_back(decide_fetch(file_window, sent_req, cfg_max, cfg_io));
      end
      if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (read_requests.size() != 0) begin
        sent_req = read_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= rawp_pkg::IN_DATA_BITS'({sent_req.file_pages, sent_req.history_count,
                                             sent_req.next_miss, sent_req.prev_page,
                                             sent_req.req_len, sent_req.page_index});
        s_tuser  <= sent_req.kind;
        send_gap = src_idle ? pick_gap() : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Fetch monitor and sink back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_off = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_fetches.size() == 0) begin
          $error("fetch transfer with no request outstanding");
          mismatches++;
        end else begin
          want = pending_fetches.pop_front();
          if (m_tuser !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, m_tuser);
            mismatches++;
          end
          if (m_tdata[31:0] !== want.read_start) begin
            $error("read_start: expected %0h, got %0h", want.read_start, m_tdata[31:0]);
            mismatches++;
          end
          if (m_tdata[47:32] !== want.read_count) begin
            $error("read_count: expected %0d, got %0d", want.read_count, m_tdata[47:32]);
            mismatches++;
          end
          if (m_tdata[63:48] !== want.mark_offset) begin
            $error("mark_offset: expected %0d, got %0d", want.mark_offset, m_tdata[63:48]);
            mismatches++;
          end
        end
      end
      if (hold_off != 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (sink_idle && $urandom_range(99) < 25) hold_off = pick_gap();
      end
    end
  end

  // Watchdog: too long without a transfer on either stream ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("readahead_window_policy_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned max_val;
    int unsigned io_val;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset limits (32 pages, no I/O size).
    add_request(KIND_SYNC,   32'd0,      16'd1,   32'd0,      32'd0,    16'd0, BIG_FILE);
    add_request(KIND_SYNC,   32'd1,      16'd1,   32'd0,      32'd0,    16'd0, BIG_FILE);
    add_request(KIND_MARKER, 32'd4,      16'd4,   32'd1,      32'd0,    16'd0, BIG_FILE);
    add_request(KIND_SYNC,   32'd28,     16'd16,  32'd27,     32'd0,    16'd0, BIG_FILE);
    add_request(KIND_MARKER, 32'd1000,   16'd4,   32'd20,     32'd1010, 16'd0, BIG_FILE);
    add_request(KIND_MARKER, 32'd2000,   16'd4,   32'd20,     32'd0,    16'd0, BIG_FILE);
    add_request(KIND_MARKER, 32'd5000,   16'd4,   32'd20,     32'd5100, 16'd0, BIG_FILE);
    add_request(KIND_SYNC,   32'd70000,  16'd3,   32'd10,     32'd0,    16'd0, BIG_FILE);
    add_request(KIND_SYNC,   32'd80000,  16'd2,   32'd5,      32'd0,    16'd10, BIG_FILE);
    add_request(KIND_SYNC,   32'd5,      16'd2,   32'd100,    32'd0,    16'd8, BIG_FILE);
    add_request(KIND_SYNC,   32'd200000, 16'd100, 32'd7,      32'd0,    16'd0, BIG_FILE);
    add_request(KIND_SYNC,   32'd300000, 16'd2,   32'd299999, 32'd0,    16'd0, BIG_FILE);
    add_request(KIND_SYNC,   32'd400000, 16'd2,   32'd400000, 32'd0,    16'd0, BIG_FILE);
    // End of file: clipped window, empty file, start past the last page.
    add_request(KIND_SYNC,   32'd10,     16'd8,   32'd9,      32'd0,    16'd0, 32'd12);
    add_request(KIND_SYNC,   32'd90000,  16'd3,   32'd10,     32'd0,    16'd0, 32'd0);
    add_request(KIND_SYNC,   32'd50,     16'd3,   32'd10,     32'd0,    16'd0, 32'd50);
    // Zero request size rounds to one page.
    add_request(KIND_SYNC,   32'd0,      16'd0,   32'd0,      32'd0,    16'd0, BIG_FILE);
    // All-ones fields, then a window that wraps past the top of the index space.
    add_request(KIND_SYNC, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF,
                32'hFFFF_FFFF);
    add_request(KIND_SYNC, 32'hFFFF_FFFC, 16'd4, 32'hFFFF_FFFB, 32'd0, 16'd0, 32'hFFFF_FFFF);
    add_request(KIND_SYNC,   32'd4,      16'd4,   32'd3,      32'd0,    16'd0, BIG_FILE);
    add_request(KIND_MARKER, 32'h8000_0000, 16'h8000, 32'h7FFF_0000, 32'h8000_0010,
                16'hFFFF, 32'hFFFF_FFFF);
    wait_idle();

    // The device I/O size widens the limit for large requests.
    set_limits(16, 64);
    add_request(KIND_SYNC,   32'd0,      16'd40,  32'd0,      32'd0,    16'd0, BIG_FILE);
    add_request(KIND_SYNC,   32'd0,      16'd100, 32'd0,      32'd0,    16'd0, BIG_FILE);
    add_request(KIND_MARKER, 32'd123456, 16'd100, 32'd7,      32'd123516, 16'd0, BIG_FILE);
    wait_idle();

    // Zero limit: every window collapses and nothing is fetched.
    set_limits(0, 0);
    add_request(KIND_SYNC,   32'd0,      16'd1,   32'd0,      32'd0,    16'd0, BIG_FILE);
    add_request(KIND_SYNC,   32'd1000,   16'd2,   32'd10,     32'd0,    16'd5, BIG_FILE);
    add_request(KIND_SYNC,   32'd1000,   16'd2,   32'd999,    32'd0,    16'd0, BIG_FILE);
    add_request(KIND_MARKER, 32'd5000,   16'd3,   32'd10,     32'd5000, 16'd0, BIG_FILE);
    wait_idle();

    // Random phases, one per limit setting. Each half ends with the sender
    // holding off until every fetch has come back.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 8) begin
        max_val = PHASE_MAX[ph];
        io_val  = PHASE_IO[ph];
      end else begin
        max_val = $urandom_range(1, 65535);
        io_val  = $urandom_range(65535);
      end
      set_limits(max_val, io_val);
      plan_window = file_window;
      for (int half = 0; half < 2; half++) begin
        src_idle  <= ($urandom_range(3) != 0);
        sink_idle <= ($urandom_range(3) != 0);
        for (int n = 0; n < PHASE_ITEMS / 2; n++) begin
          queue_request(make_request());
        end
        wait_idle();
      end
    end

    if (mismatches == 0) begin
      $display("readahead_window_policy_tb: PASS");
    end else begin
      $display("readahead_window_policy_tb: FAIL");
    end
    $finish;
  end

endmodule
